FILE: rtl/core/ttd_pkg.sv
package ttd_pkg;

  localparam int ADC_BITS_DEF = 12;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int TIME_W       = 32;
  localparam int OFFSET_W     = 12;
  localparam int SPAN_W       = 16;
  localparam int MODE_W       = 2;

  localparam logic [CFG_IDX_W-1:0] REG_CALIB_START    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CALIB_TIME     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SWITCH_DEBOUNCE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_OFFSET   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_OFFSET = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_X_MARGIN       = 3'd5;

  localparam logic [TIME_W-1:0]   CALIB_START_RST    = 32'd0;
  localparam logic [SPAN_W-1:0]   CALIB_TIME_RST     = 16'd1200;
  localparam logic [SPAN_W-1:0]   SWITCH_DEBOUNCE_RST = 16'd300;
  localparam logic [OFFSET_W-1:0] PRESS_OFFSET_RST   = 12'd250;
  localparam logic [OFFSET_W-1:0] RELEASE_OFFSET_RST = 12'd120;
  localparam logic [OFFSET_W-1:0] X_MARGIN_RST       = 12'd250;

  localparam logic [MODE_W-1:0] MODE_ODOMETER = 2'd0;
  localparam logic [MODE_W-1:0] MODE_JOURNEY  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ENGINE   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_INVALID  = 2'd3;

  typedef struct packed {
    logic [TIME_W-1:0]   calib_start_ms;
    logic [SPAN_W-1:0]   calib_time_ms;
    logic [SPAN_W-1:0]   switch_debounce_ms;
    logic [OFFSET_W-1:0] press_offset;
    logic [OFFSET_W-1:0] release_offset;
    logic [OFFSET_W-1:0] x_margin;
  } cfg_t;

  typedef struct packed {
    logic              is_calibrated;
    logic              touch_down;
    logic              mode_switched;
    logic [MODE_W-1:0] display_mode;
  } status_t;

endpackage

FILE: rtl/core/ttd_cfg_regs.sv
module ttd_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  input  logic [ttd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ttd_pkg::CFG_DATA_W-1:0]    cfg_data,
  output ttd_pkg::cfg_t                     cfg_o
);

  ttd_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.calib_start_ms     <= ttd_pkg::CALIB_START_RST;
      cfg_r.calib_time_ms      <= ttd_pkg::CALIB_TIME_RST;
      cfg_r.switch_debounce_ms <= ttd_pkg::SWITCH_DEBOUNCE_RST;
      cfg_r.press_offset       <= ttd_pkg::PRESS_OFFSET_RST;
      cfg_r.release_offset     <= ttd_pkg::RELEASE_OFFSET_RST;
      cfg_r.x_margin           <= ttd_pkg::X_MARGIN_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        ttd_pkg::REG_CALIB_START:     cfg_r.calib_start_ms <= cfg_data;
        ttd_pkg::REG_CALIB_TIME:      cfg_r.calib_time_ms <= cfg_data[ttd_pkg::SPAN_W-1:0];
        ttd_pkg::REG_SWITCH_DEBOUNCE: begin
          cfg_r.switch_debounce_ms <= cfg_data[ttd_pkg::SPAN_W-1:0];
        end
        ttd_pkg::REG_PRESS_OFFSET:    cfg_r.press_offset <= cfg_data[ttd_pkg::OFFSET_W-1:0];
        ttd_pkg::REG_RELEASE_OFFSET:  cfg_r.release_offset <= cfg_data[ttd_pkg::OFFSET_W-1:0];
        ttd_pkg::REG_X_MARGIN:        cfg_r.x_margin <= cfg_data[ttd_pkg::OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_r;

endmodule

FILE: rtl/core/ttd_smooth.sv
module ttd_smooth #(
  parameter int ADC_BITS = ttd_pkg::ADC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                upd,
  input  logic [ADC_BITS-1:0] raw,
  output logic [ADC_BITS-1:0] ema_nxt
);

  // 7*ema + 3*raw stays below 10 * 2^ADC_BITS, so four extra bits suffice.
  localparam int SUM_W = ADC_BITS + 4;
  localparam int SHIFT = SUM_W + 3;
  localparam int MUL_W = SUM_W + SHIFT;
  localparam logic [SHIFT-1:0] RECIP =
    SHIFT'(((64'd1 << SHIFT) + 64'd9) / 64'd10);

  logic [ADC_BITS-1:0] ema_r;
  logic [SUM_W-1:0]    sum;
  logic [MUL_W-1:0]    prod;

  assign sum = (SUM_W'(ema_r) << 3) - SUM_W'(ema_r) + (SUM_W'(raw) << 1) + SUM_W'(raw);
  assign prod = MUL_W'(sum) * MUL_W'(RECIP);
  assign ema_nxt = prod[SHIFT +: ADC_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ema_r <= '0;
    end else if (upd) begin
      ema_r <= ema_nxt;
    end
  end

endmodule

FILE: rtl/core/ttd_tap_ctl.sv
module ttd_tap_ctl #(
  parameter int ADC_BITS = ttd_pkg::ADC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            upd,
  input  ttd_pkg::cfg_t                   cfg,
  input  logic [ADC_BITS-1:0]             ema_y_nxt,
  input  logic [ADC_BITS-1:0]             ema_x_nxt,
  input  logic [ttd_pkg::TIME_W-1:0]      now_ms,
  output ttd_pkg::status_t                status_nxt
);

  localparam int TH_W = ((ADC_BITS > ttd_pkg::OFFSET_W) ? ADC_BITS : ttd_pkg::OFFSET_W) + 1;

  logic [ADC_BITS-1:0]              base_y_r;
  logic [ADC_BITS-1:0]              base_x_r;
  logic                             cal_r;
  logic                             pressed_r;
  logic [ttd_pkg::TIME_W-1:0]       last_switch_r;
  logic [ttd_pkg::MODE_W-1:0]       mode_r;

  logic                             latch_now;
  logic                             cal_nxt;
  logic                             pressed_nxt;
  logic                             switched;
  logic [ttd_pkg::MODE_W-1:0]       mode_nxt;
  logic [ttd_pkg::TIME_W-1:0]       since_start;
  logic [ttd_pkg::TIME_W-1:0]       since_switch;
  logic [TH_W-1:0]                  thr_press_y;
  logic [TH_W-1:0]                  thr_press_x;
  logic [TH_W-1:0]                  thr_rel_y;
  logic [TH_W-1:0]                  thr_rel_x;
  logic                             hit_y;
  logic                             hit_x;
  logic                             active;
  logic                             release_ok;

  assign since_start  = now_ms - cfg.calib_start_ms;
  assign since_switch = now_ms - last_switch_r;
  assign latch_now    = !cal_r && (since_start >= ttd_pkg::TIME_W'(cfg.calib_time_ms));
  assign cal_nxt      = cal_r || latch_now;

  assign thr_press_y = TH_W'(base_y_r) + TH_W'(cfg.press_offset);
  assign thr_press_x = TH_W'(base_x_r) + TH_W'(cfg.x_margin);
  assign thr_rel_y   = TH_W'(base_y_r) + TH_W'(cfg.release_offset);
  assign thr_rel_x   = TH_W'(base_x_r) + TH_W'(cfg.x_margin >> 1);

  // On the sample that latches the baselines, the filtered value equals the
  // new baseline, so only a zero offset can register a press.
  assign hit_y = latch_now ? (cfg.press_offset == '0) : (TH_W'(ema_y_nxt) >= thr_press_y);
  assign hit_x = latch_now ? (cfg.x_margin == '0) : (TH_W'(ema_x_nxt) >= thr_press_x);
  assign active = cal_nxt && (hit_y || hit_x);
  assign release_ok = (TH_W'(ema_y_nxt) <= thr_rel_y) && (TH_W'(ema_x_nxt) <= thr_rel_x);

  always_comb begin
    pressed_nxt = pressed_r;
    switched    = 1'b0;
    mode_nxt    = mode_r;
    if (!pressed_r && active) begin
      pressed_nxt = 1'b1;
      if (since_switch > ttd_pkg::TIME_W'(cfg.switch_debounce_ms)) begin
        switched = 1'b1;
        case (mode_r)
          ttd_pkg::MODE_ODOMETER: mode_nxt = ttd_pkg::MODE_JOURNEY;
          ttd_pkg::MODE_JOURNEY:  mode_nxt = ttd_pkg::MODE_ENGINE;
          default:                mode_nxt = ttd_pkg::MODE_ODOMETER;
        endcase
      end
    end else if (pressed_r && release_ok) begin
      pressed_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_y_r      <= '0;
      base_x_r      <= '0;
      cal_r         <= 1'b0;
      pressed_r     <= 1'b0;
      last_switch_r <= '0;
      mode_r        <= ttd_pkg::MODE_ODOMETER;
    end else if (upd) begin
      if (latch_now) begin
        base_y_r <= ema_y_nxt;
        base_x_r <= ema_x_nxt;
      end
      if (switched) begin
        last_switch_r <= now_ms;
      end
      cal_r     <= cal_nxt;
      pressed_r <= pressed_nxt;
      mode_r    <= mode_nxt;
    end
  end

  assign status_nxt.is_calibrated = cal_nxt;
  assign status_nxt.touch_down    = pressed_nxt;
  assign status_nxt.mode_switched = switched;
  assign status_nxt.display_mode  = mode_nxt;

endmodule

FILE: rtl/core/touch_tap_detector.sv
// Tap detector for a resistive touch panel. Each input transaction is one
// poll sample (raw Y, raw X, millisecond timestamp) and yields exactly one
// output transaction with the smoothed readings, the calibration flag, the
// pressed state, a mode-switch strobe and the current display mode. A sample
// is registered on entry, and the whole filter-and-threshold update of the
// state registers is then made into an output register when that register is
// empty or not stalled, so one transaction is taken every clock cycle while
// the output does not stall. One further sample can be held while a result
// is stalled on the output. Configuration writes are always ready and are
// meant for when the block is idle.
module touch_tap_detector #(
  parameter int ADC_BITS = ttd_pkg::ADC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [ADC_BITS-1:0]            in_raw_y,
  input  logic [ADC_BITS-1:0]            in_raw_x,
  input  logic [ttd_pkg::TIME_W-1:0]     in_now_ms,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ADC_BITS-1:0]            out_filtered_y,
  output logic [ADC_BITS-1:0]            out_filtered_x,
  output logic                           out_is_calibrated,
  output logic                           out_touch_down,
  output logic                           out_mode_switched,
  output logic [ttd_pkg::MODE_W-1:0]     out_display_mode,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ttd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ttd_pkg::CFG_DATA_W-1:0] cfg_data
);

  ttd_pkg::cfg_t    cfg;
  ttd_pkg::status_t status_nxt;
  ttd_pkg::status_t status_r;

  logic                          s1_vld_r;
  logic [ADC_BITS-1:0]           s1_raw_y_r;
  logic [ADC_BITS-1:0]           s1_raw_x_r;
  logic [ttd_pkg::TIME_W-1:0]    s1_now_r;
  logic                          out_vld_r;
  logic [ADC_BITS-1:0]           filt_y_r;
  logic [ADC_BITS-1:0]           filt_x_r;
  logic [ADC_BITS-1:0]           ema_y_nxt;
  logic [ADC_BITS-1:0]           ema_x_nxt;
  logic                          adv;
  logic                          in_acc;
  logic                          upd;

  assign adv      = !out_vld_r || !out_stall;
  assign in_stall = s1_vld_r && !adv;
  assign in_acc   = in_valid && !in_stall;
  assign upd      = s1_vld_r && adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_vld_r <= 1'b1;
      end else if (adv) begin
        s1_vld_r <= 1'b0;
      end
      if (adv) begin
        out_vld_r <= s1_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_raw_y_r <= in_raw_y;
      s1_raw_x_r <= in_raw_x;
      s1_now_r   <= in_now_ms;
    end
    if (upd) begin
      filt_y_r <= ema_y_nxt;
      filt_x_r <= ema_x_nxt;
      status_r <= status_nxt;
    end
  end

  ttd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  ttd_smooth #(.ADC_BITS(ADC_BITS)) u_smooth_y (
    .clk     (clk),
    .rst_n   (rst_n),
    .upd     (upd),
    .raw     (s1_raw_y_r),
    .ema_nxt (ema_y_nxt)
  );

  ttd_smooth #(.ADC_BITS(ADC_BITS)) u_smooth_x (
    .clk     (clk),
    .rst_n   (rst_n),
    .upd     (upd),
    .raw     (s1_raw_x_r),
    .ema_nxt (ema_x_nxt)
  );

  ttd_tap_ctl #(.ADC_BITS(ADC_BITS)) u_ctl (
    .clk        (clk),
    .rst_n      (rst_n),
    .upd        (upd),
    .cfg        (cfg),
    .ema_y_nxt  (ema_y_nxt),
    .ema_x_nxt  (ema_x_nxt),
    .now_ms     (s1_now_r),
    .status_nxt (status_nxt)
  );

  assign out_valid         = out_vld_r;
  assign out_filtered_y    = filt_y_r;
  assign out_filtered_x    = filt_x_r;
  assign out_is_calibrated = status_r.is_calibrated;
  assign out_touch_down    = status_r.touch_down;
  assign out_mode_switched = status_r.mode_switched;
  assign out_display_mode  = status_r.display_mode;

endmodule

FILE: rtl/core/ttd_checker.sv
module ttd_checker #(
  parameter int ADC_BITS = ttd_pkg::ADC_BITS_DEF
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [ADC_BITS-1:0]        out_filtered_y,
  input logic [ADC_BITS-1:0]        out_filtered_x,
  input logic                       out_is_calibrated,
  input logic                       out_touch_down,
  input logic                       out_mode_switched,
  input logic [ttd_pkg::MODE_W-1:0] out_display_mode
);

  // A stalled result transaction holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_filtered_y) &&
    $stable(out_filtered_x) && $stable(out_touch_down) && $stable(out_display_mode))
    else $error("stalled result changed");

  a_no_press_uncal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_calibrated |-> !out_touch_down && !out_mode_switched)
    else $error("press reported before calibration");

  a_switch_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mode_switched |-> out_touch_down)
    else $error("mode switched without a press");

  a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_display_mode != ttd_pkg::MODE_INVALID)
    else $error("display mode out of range");

endmodule

bind touch_tap_detector ttd_checker #(.ADC_BITS(ADC_BITS)) u_ttd_checker (.*);

FILE: bench/touch_tap_detector_tb.sv
module touch_tap_detector_tb;
  import ttd_pkg::*;

  localparam int ADC_W = ADC_BITS_DEF;
  localparam int ADC_MAX = (1 << ADC_W) - 1;
  localparam logic [ADC_W-1:0] ADC_FULL = '1;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LOW = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HIGH = 3'd7;

  typedef struct {
    logic [ADC_W-1:0]  filtered_y;
    logic [ADC_W-1:0]  filtered_x;
    logic              is_calibrated;
    logic              touch_down;
    logic              mode_switched;
    logic [MODE_W-1:0] display_mode;
  } tap_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [ADC_W-1:0] in_raw_y = '0;
  logic [ADC_W-1:0] in_raw_x = '0;
  logic [TIME_W-1:0] in_now_ms = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [ADC_W-1:0] out_filtered_y;
  logic [ADC_W-1:0] out_filtered_x;
  logic out_is_calibrated;
  logic out_touch_down;
  logic out_mode_switched;
  logic [MODE_W-1:0] out_display_mode;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  cfg_t regs = '{calib_start_ms: CALIB_START_RST, calib_time_ms: CALIB_TIME_RST,
                 switch_debounce_ms: SWITCH_DEBOUNCE_RST, press_offset: PRESS_OFFSET_RST,
                 release_offset: RELEASE_OFFSET_RST, x_margin: X_MARGIN_RST};
  logic [ADC_W-1:0] smooth_y = '0;
  logic [ADC_W-1:0] smooth_x = '0;
  logic [ADC_W-1:0] base_y = '0;
  logic [ADC_W-1:0] base_x = '0;
  logic calibrated = 1'b0;
  logic pressed = 1'b0;
  logic [TIME_W-1:0] last_switch_ms = '0;
  logic [MODE_W-1:0] mode = MODE_ODOMETER;

  tap_report_t pending_reports[$];
  int error_count = 0;
  int sent_count = 0;
  int checked_count = 0;
  int cycle_count = 0;
  int idle_pct = 0;
  int stall_left = 0;
  int rest_y = 0;
  int rest_x = 0;
  logic [TIME_W-1:0] now_cur = '0;

  touch_tap_detector uut (.*);

  always #1 clk = ~clk;

  function automatic logic [ADC_W-1:0] smooth_step(logic [ADC_W-1:0] prev,
                                                   logic [ADC_W-1:0] raw);
    int unsigned acc;
    acc = 7 * prev + 3 * raw;
    return ADC_W'(acc / 10);
  endfunction

  function automatic tap_report_t advance_tap_model(logic [ADC_W-1:0] raw_y, raw_x,
                                                    logic [TIME_W-1:0] now);
    tap_report_t r;
    logic [TIME_W-1:0] since;
    logic [ADC_W:0] press_y, press_x, release_y, release_x;
    logic active;
    logic switched;
    switched = 1'b0;
    smooth_y = smooth_step(smooth_y, raw_y);
    smooth_x = smooth_step(smooth_x, raw_x);
    since = now - regs.calib_start_ms;
    if (!calibrated && since >= regs.calib_time_ms) begin
      base_y = smooth_y;
      base_x = smooth_x;
      calibrated = 1'b1;
    end
    press_y = base_y + regs.press_offset;
    press_x = base_x + regs.x_margin;
    release_y = base_y + regs.release_offset;
    release_x = base_x + (regs.x_margin >> 1);
    active = calibrated && (smooth_y >= press_y || smooth_x >= press_x);
    since = now - last_switch_ms;
    if (!pressed && active) begin
      pressed = 1'b1;
      if (since > regs.switch_debounce_ms) begin
        mode = (mode >= MODE_ENGINE) ? MODE_ODOMETER : mode + 1'b1;
        last_switch_ms = now;
        switched = 1'b1;
      end
    end else if (pressed && smooth_y <= release_y && smooth_x <= release_x) begin
      pressed = 1'b0;
    end
    r.filtered_y = smooth_y;
    r.filtered_x = smooth_x;
    r.is_calibrated = calibrated;
    r.touch_down = pressed;
    r.mode_switched = switched;
    r.display_mode = mode;
    return r;
  endfunction

  function automatic logic [ADC_W-1:0] jitter(int level, int spread);
    int v;
    v = level + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > ADC_MAX) v = ADC_MAX;
    return ADC_W'(v);
  endfunction

  task automatic compare_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t ERROR %s: expected %0d, actual %0d", $time, field, want, got);
      error_count++;
    end
  endtask

  // Results are checked before the sample accepted at the same edge is predicted.
  always @(posedge clk) begin
    tap_report_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_reports.size() == 0) begin
          $display("%0t ERROR unexpected result: expected none, actual y=%0d x=%0d mode=%0d",
                   $time, out_filtered_y, out_filtered_x, out_display_mode);
          error_count++;
        end else begin
          want = pending_reports.pop_front();
          compare_field("filtered_y", 32'(want.filtered_y), 32'(out_filtered_y));
          compare_field("filtered_x", 32'(want.filtered_x), 32'(out_filtered_x));
          compare_field("is_calibrated", 32'(want.is_calibrated), 32'(out_is_calibrated));
          compare_field("touch_down", 32'(want.touch_down), 32'(out_touch_down));
          compare_field("mode_switched", 32'(want.mode_switched), 32'(out_mode_switched));
          compare_field("display_mode", 32'(want.display_mode), 32'(out_display_mode));
          checked_count++;
        end
      end
      if (in_valid && !in_stall) begin
        pending_reports.push_back(advance_tap_model(in_raw_y, in_raw_x, in_now_ms));
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      stall_left = $urandom_range(0, 12);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_sample(logic [ADC_W-1:0] raw_y, raw_x, logic [TIME_W-1:0] now);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_raw_y <= raw_y;
    in_raw_x <= raw_x;
    in_now_ms <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (checked_count < sent_count) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (index)
      REG_CALIB_START:     regs.calib_start_ms = data;
      REG_CALIB_TIME:      regs.calib_time_ms = data[SPAN_W-1:0];
      REG_SWITCH_DEBOUNCE: regs.switch_debounce_ms = data[SPAN_W-1:0];
      REG_PRESS_OFFSET:    regs.press_offset = data[OFFSET_W-1:0];
      REG_RELEASE_OFFSET:  regs.release_offset = data[OFFSET_W-1:0];
      REG_X_MARGIN:        regs.x_margin = data[OFFSET_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_thresholds(logic [OFFSET_W-1:0] press_lvl, release_lvl, margin,
                                logic [SPAN_W-1:0] debounce);
    drain_results();
    write_reg(REG_PRESS_OFFSET, CFG_DATA_W'(press_lvl));
    write_reg(REG_RELEASE_OFFSET, CFG_DATA_W'(release_lvl));
    write_reg(REG_X_MARGIN, CFG_DATA_W'(margin));
    write_reg(REG_SWITCH_DEBOUNCE, CFG_DATA_W'(debounce));
  endtask

  // Mostly taps on one or both axes around the resting level, with some noise
  // and the odd jump of the timestamp.
  task automatic run_taps(int count);
    int done;
    int hold;
    int release_len;
    int axis;
    int lift_y;
    int lift_x;
    done = 0;
    while (done < count) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          now_cur += $urandom_range(0, 200);
          send_sample(ADC_W'($urandom_range(0, ADC_MAX)), ADC_W'($urandom_range(0, ADC_MAX)),
                      now_cur);
          done++;
        end
        2: begin
          now_cur = $urandom();
          send_sample(ADC_W'($urandom_range(0, ADC_MAX)), ADC_W'($urandom_range(0, ADC_MAX)),
                      now_cur);
          done++;
        end
        default: begin
          axis = $urandom_range(0, 2);
          lift_y = (axis == 1) ? 0 : $urandom_range(0, 2500);
          lift_x = (axis == 0) ? 0 : $urandom_range(0, 2500);
          hold = $urandom_range(1, 10);
          release_len = $urandom_range(1, 10);
          repeat (hold) begin
            now_cur += $urandom_range(0, 60);
            send_sample(jitter(rest_y + lift_y, 40), jitter(rest_x + lift_x, 40), now_cur);
          end
          repeat (release_len) begin
            now_cur += $urandom_range(0, 60);
            send_sample(jitter(rest_y, 20), jitter(rest_x, 20), now_cur);
          end
          done += hold + release_len;
        end
      endcase
    end
  endtask

  task automatic test_precalibration();
    write_reg(REG_CALIB_START, 32'hFFFF_FFF0);
    write_reg(REG_CALIB_TIME, 32'h0000_FFFF);
    write_reg(REG_SPARE_LOW, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_HIGH, 32'h0000_0000);
    send_sample('0, '0, 32'hFFFF_FFF0);
    send_sample(ADC_FULL, ADC_FULL, 32'hFFFF_FFFF);
    send_sample(ADC_FULL, '0, 32'h0000_0000);
    send_sample('0, ADC_FULL, 32'h0000_0001);
    send_sample(ADC_FULL, ADC_FULL, 32'h0000_A5A5);
  endtask

  task automatic test_calibration();
    drain_results();
    rest_y = $urandom_range(300, 900);
    rest_x = $urandom_range(300, 900);
    now_cur = $urandom();
    write_reg(REG_CALIB_START, now_cur);
    write_reg(REG_CALIB_TIME, CFG_DATA_W'(CALIB_TIME_RST));
    for (int i = 0; i < 18; i++) begin
      send_sample(jitter(rest_y, 20), jitter(rest_x, 20), now_cur + 60 * i);
    end
    send_sample(jitter(rest_y, 20), jitter(rest_x, 20), now_cur + CALIB_TIME_RST - 1);
    now_cur += CALIB_TIME_RST;
    send_sample(jitter(rest_y, 20), jitter(rest_x, 20), now_cur);
  endtask

  task automatic test_taps_default();
    set_thresholds(PRESS_OFFSET_RST, RELEASE_OFFSET_RST, X_MARGIN_RST, SWITCH_DEBOUNCE_RST);
    idle_pct = 15;
    run_taps(100);
    drain_results();
    run_taps(100);
  endtask

  task automatic test_taps_eager();
    set_thresholds('0, '1, '0, '0);
    idle_pct = 30;
    run_taps(80);
  endtask

  task automatic test_taps_unreachable();
    set_thresholds('1, '0, '1, '1);
    write_reg(REG_CALIB_START, 32'hFFFF_FFFF);
    write_reg(REG_CALIB_TIME, 32'h0000_0000);
    idle_pct = 5;
    run_taps(80);
  endtask

  task automatic test_taps_random_config();
    repeat (3) begin
      drain_results();
      write_reg(REG_CALIB_START, $urandom());
      write_reg(REG_CALIB_TIME, $urandom_range(0, 65535));
      write_reg(REG_SWITCH_DEBOUNCE, $urandom_range(0, 1) ? $urandom_range(0, 400)
                                                           : $urandom_range(0, 65535));
      write_reg(REG_PRESS_OFFSET, $urandom_range(0, 1) ? $urandom_range(0, 600)
                                                       : $urandom_range(0, ADC_MAX));
      write_reg(REG_RELEASE_OFFSET, $urandom_range(0, 1) ? $urandom_range(0, 400)
                                                         : $urandom_range(0, ADC_MAX));
      write_reg(REG_X_MARGIN, $urandom_range(0, 1) ? $urandom_range(0, 600)
                                                   : $urandom_range(0, ADC_MAX));
      idle_pct = 15 * $urandom_range(0, 2);
      run_taps(80);
    end
  endtask

  task automatic test_steady_stream();
    set_thresholds(12'd180, 12'd90, 12'd300, 16'd150);
    idle_pct = 0;
    run_taps(100);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_precalibration();
    test_calibration();
    test_taps_default();
    test_taps_eager();
    test_taps_unreachable();
    test_taps_random_config();
    test_steady_stream();
    drain_results();
    if (error_count == 0 && pending_reports.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
